[sv/char_lcd_i2c_expander_sequencer_top_assert.svh]
// Assertion macros for the character LCD sequencer.
`ifndef CHAR_LCD_I2C_EXPANDER_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_I2C_EXPANDER_SEQUENCER_TOP_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define LCDSEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LCDSEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/lcdseq_pkg.sv]
`default_nettype none

package lcdseq_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegDevAddr = 2'd0;
  localparam logic [1:0] RegMaxRows = 2'd1;
  localparam logic [1:0] RegMaxCols = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [6:0] DevAddrReset = 7'd39;
  localparam logic [2:0] MaxRowsReset = 3'd2;
  localparam logic [5:0] MaxColsReset = 6'd16;

  // Opcodes of an input item.
  localparam logic [2:0] OpInit     = 3'd0;
  localparam logic [2:0] OpCommand  = 3'd1;
  localparam logic [2:0] OpChar     = 3'd2;
  localparam logic [2:0] OpClear    = 3'd3;
  localparam logic [2:0] OpHome     = 3'd4;
  localparam logic [2:0] OpCursor   = 3'd5;
  localparam logic [2:0] OpNextLine = 3'd6;
  localparam logic [2:0] OpRightAln = 3'd7;

  // LCD commands and DDRAM row offsets.
  localparam logic [7:0] CmdClear   = 8'h01;
  localparam logic [7:0] CmdHome    = 8'h02;
  localparam logic [7:0] CmdSetDdr  = 8'h80;
  localparam logic [6:0] RowOffset0 = 7'h00;
  localparam logic [6:0] RowOffset1 = 7'h40;
  localparam logic [6:0] RowOffset2 = 7'h14;
  localparam logic [6:0] RowOffset3 = 7'h54;

  // Base waits of the three bytes of one nibble, in microseconds.
  localparam logic [13:0] WaitSetup  = 14'd0;
  localparam logic [13:0] WaitPulse  = 14'd1;
  localparam logic [13:0] WaitSettle = 14'd500;

  // Microcode entry points.
  localparam logic [3:0] EntryInit    = 4'd0;
  localparam logic [3:0] EntryOperand = 4'd12;

  // Where a step takes its nibble from.
  typedef enum logic [1:0] {
    SRC_CONST = 2'b01,
    SRC_OPHI  = 2'b10,
    SRC_OPLO  = 2'b11
  } nib_src_e;

  // Extra wait added to the final byte of a nibble.
  typedef enum logic [2:0] {
    WX_NONE  = 3'd0,
    WX_10000 = 3'd1,
    WX_200   = 3'd2,
    WX_80    = 3'd3,
    WX_2000  = 3'd4,
    WX_OPER  = 3'd5
  } wait_x_e;

  // One control word: a nibble to send, its extra wait, end of program.
  typedef struct packed {
    nib_src_e   src;
    logic [3:0] nib;
    wait_x_e    wx;
    logic       fin;
  } uword_t;

  // Microcode: init program at step 0, operand byte program at step 12.
  function automatic uword_t ucode(input logic [3:0] step);
    uword_t w;
    case (step)
      4'd0:    w = '{SRC_CONST, 4'h3, WX_10000, 1'b0};
      4'd1:    w = '{SRC_CONST, 4'h3, WX_200,   1'b0};
      4'd2:    w = '{SRC_CONST, 4'h3, WX_NONE,  1'b0};
      4'd3:    w = '{SRC_CONST, 4'h2, WX_80,    1'b0};
      4'd4:    w = '{SRC_CONST, 4'h2, WX_NONE,  1'b0};
      4'd5:    w = '{SRC_CONST, 4'h8, WX_80,    1'b0};
      4'd6:    w = '{SRC_CONST, 4'h0, WX_NONE,  1'b0};
      4'd7:    w = '{SRC_CONST, 4'h1, WX_2000,  1'b0};
      4'd8:    w = '{SRC_CONST, 4'h0, WX_NONE,  1'b0};
      4'd9:    w = '{SRC_CONST, 4'h6, WX_80,    1'b0};
      4'd10:   w = '{SRC_CONST, 4'h0, WX_NONE,  1'b0};
      4'd11:   w = '{SRC_CONST, 4'hC, WX_NONE,  1'b1};
      4'd12:   w = '{SRC_OPHI,  4'h0, WX_NONE,  1'b0};
      4'd13:   w = '{SRC_OPLO,  4'h0, WX_OPER,  1'b1};
      default: w = '{SRC_CONST, 4'h0, WX_NONE,  1'b1};
    endcase
    return w;
  endfunction

  // Extra wait in microseconds; the operand program waits long for clear and home.
  function automatic logic [13:0] extra_wait(input wait_x_e wx, input logic long_wait);
    logic [13:0] v;
    case (wx)
      WX_10000: v = 14'd10000;
      WX_200:   v = 14'd200;
      WX_80:    v = 14'd80;
      WX_2000:  v = 14'd2000;
      WX_OPER:  v = long_wait ? 14'd2000 : 14'd0;
      default:  v = 14'd0;
    endcase
    return v;
  endfunction

  // DDRAM row offset of a display row.
  function automatic logic [6:0] row_offset(input logic [1:0] r);
    logic [6:0] v;
    case (r)
      2'd0:    v = RowOffset0;
      2'd1:    v = RowOffset1;
      2'd2:    v = RowOffset2;
      default: v = RowOffset3;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[sv/char_lcd_i2c_expander_sequencer_top.sv]
// Character LCD sequencer for a 4-bit mode LCD controller behind an I2C port expander.
//
// Input: an item is taken at a rising edge with start_i high and busy_o low.
// Its opcode expands into expander bytes, each shown on the result ports for
// exactly one cycle with strobe_o high; last_o marks the final byte of the item.
// The receiver cannot stall, so bytes leave one per cycle without gaps.
// The item is registered into the sequencer state, and each of its bytes is then
// registered into the result register before it is shown on the ports.
// Each item yields six bytes (init yields 36), set by the microcode sequencer, which
// walks each nibble step through its setup, enable-high and enable-low bytes.
// busy_o drops in the cycle that produces the final byte, so the next item
// can be taken at that edge and its bytes follow directly.
// Configuration: cfg_we_i writes register cfg_index_i (0 device address, 1 max rows,
// 2 max columns); other indexes are ignored. Write only while the block is idle;
// the block itself does not enforce it. Reset: the sequencer goes idle, no result is
// pending, and the registers return to address 39, 2 rows and 16 columns.
`default_nettype none

module char_lcd_i2c_expander_sequencer_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [2:0]  opcode_i,
  input  wire  [7:0]  data_byte_i,
  input  wire  [2:0]  row_i,
  input  wire  [5:0]  column_i,
  input  wire  [7:0]  text_length_i,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [6:0]  cfg_data_i,
  output logic        strobe_o,
  output logic [7:0]  address_byte_o,
  output logic [7:0]  expander_byte_o,
  output logic [13:0] wait_after_us_o,
  output logic        row_clamped_o,
  output logic        column_saturated_o,
  output logic        last_o
);

  // Configuration registers.
  logic [6:0] dev_addr_q;
  logic [2:0] max_rows_q;
  logic [5:0] max_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= lcdseq_pkg::DevAddrReset;
      max_rows_q <= lcdseq_pkg::MaxRowsReset;
      max_cols_q <= lcdseq_pkg::MaxColsReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcdseq_pkg::RegDevAddr: dev_addr_q <= cfg_data_i;
        lcdseq_pkg::RegMaxRows: max_rows_q <= cfg_data_i[2:0];
        lcdseq_pkg::RegMaxCols: max_cols_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  logic       busy_q;
  logic [3:0] step_q, step_d;
  logic [1:0] phase_q, phase_d;
  logic       accept;
  logic       fin;

  // Item operand, latched at accept.
  logic [7:0] oper_q, oper_d;
  logic       rs_q, rs_d;
  logic       long_q, long_d;
  logic       rflag_q, rflag_d;
  logic       cflag_q, cflag_d;

  // Cursor address: clamp the row, derive the column, add the row offset.
  logic [1:0] row_lim;
  logic [2:0] row_req;
  logic [1:0] row_use;
  logic       row_over;
  logic [5:0] col_use;
  logic       col_neg;
  logic [6:0] ddr_addr;

  always_comb begin
    if (max_rows_q == 3'd0) begin
      row_lim = 2'd0;
    end else if (max_rows_q > 3'd4) begin
      row_lim = 2'd3;
    end else begin
      row_lim = 2'(max_rows_q - 3'd1);
    end
    row_req = (opcode_i == lcdseq_pkg::OpNextLine) ? 3'd1 : row_i;
    row_over = row_req > {1'b0, row_lim};
    row_use = row_over ? row_lim : row_req[1:0];
    col_neg = text_length_i > {2'b00, max_cols_q};
    case (opcode_i)
      lcdseq_pkg::OpCursor:   col_use = column_i;
      lcdseq_pkg::OpRightAln: col_use = col_neg ? 6'd0 : (max_cols_q - text_length_i[5:0]);
      default:                col_use = 6'd0;
    endcase
    ddr_addr = {1'b0, col_use} + lcdseq_pkg::row_offset(row_use);
  end

  // Operand byte and flags for the item's program.
  always_comb begin
    oper_d  = lcdseq_pkg::CmdSetDdr | {1'b0, ddr_addr};
    rs_d    = 1'b0;
    long_d  = 1'b0;
    rflag_d = 1'b0;
    cflag_d = 1'b0;
    case (opcode_i)
      lcdseq_pkg::OpInit: ;
      lcdseq_pkg::OpCommand: oper_d = data_byte_i;
      lcdseq_pkg::OpChar: begin
        oper_d = data_byte_i;
        rs_d   = 1'b1;
      end
      lcdseq_pkg::OpClear: begin
        oper_d = lcdseq_pkg::CmdClear;
        long_d = 1'b1;
      end
      lcdseq_pkg::OpHome: begin
        oper_d = lcdseq_pkg::CmdHome;
        long_d = 1'b1;
      end
      lcdseq_pkg::OpCursor, lcdseq_pkg::OpNextLine: rflag_d = row_over;
      lcdseq_pkg::OpRightAln: begin
        rflag_d = row_over;
        cflag_d = col_neg;
      end
      default: ;
    endcase
  end

  // Current control word and the byte it produces in this phase.
  lcdseq_pkg::uword_t uw;
  logic [3:0]  nib;
  logic        en_bit;
  logic [13:0] wait_val;

  always_comb begin
    uw = lcdseq_pkg::ucode(step_q);
    case (uw.src)
      lcdseq_pkg::SRC_OPHI: nib = oper_q[7:4];
      lcdseq_pkg::SRC_OPLO: nib = oper_q[3:0];
      default:              nib = uw.nib;
    endcase
    case (phase_q)
      2'd0: begin
        en_bit   = 1'b0;
        wait_val = lcdseq_pkg::WaitSetup;
      end
      2'd1: begin
        en_bit   = 1'b1;
        wait_val = lcdseq_pkg::WaitPulse;
      end
      default: begin
        en_bit   = 1'b0;
        wait_val = lcdseq_pkg::WaitSettle + lcdseq_pkg::extra_wait(uw.wx, long_q);
      end
    endcase
  end

  // Step counter: three phases per step, stop after the final step.
  assign fin    = busy_q && uw.fin && (phase_q == 2'd2);
  assign busy_o = busy_q && !fin;
  assign accept = start_i && !busy_o;

  always_comb begin
    step_d  = step_q;
    phase_d = phase_q;
    if (accept) begin
      step_d  = (opcode_i == lcdseq_pkg::OpInit) ? lcdseq_pkg::EntryInit
                                                 : lcdseq_pkg::EntryOperand;
      phase_d = 2'd0;
    end else if (busy_q) begin
      if (phase_q == 2'd2) begin
        phase_d = 2'd0;
        step_d  = step_q + 4'd1;
      end else begin
        phase_d = phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= lcdseq_pkg::EntryInit;
      phase_q <= 2'd0;
    end else begin
      busy_q  <= accept || busy_o;
      step_q  <= step_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      oper_q  <= oper_d;
      rs_q    <= rs_d;
      long_q  <= long_d;
      rflag_q <= rflag_d;
      cflag_q <= cflag_d;
    end
  end

  // Result register: one expander byte per busy cycle.
  logic strobe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      address_byte_o     <= {dev_addr_q, 1'b0};
      expander_byte_o    <= {nib, 1'b1, en_bit, 1'b0, rs_q};
      wait_after_us_o    <= wait_val;
      row_clamped_o      <= rflag_q;
      column_saturated_o <= cflag_q;
      last_o             <= fin;
    end
  end

  assign strobe_o = strobe_q;

  // Protocol checks; mid_item marks a strobed byte that is not the last of its item.
  logic       mid_item;
  logic [1:0] item_flags;

  assign mid_item   = strobe_q && !last_o;
  assign item_flags = {row_clamped_o, column_saturated_o};

  `include "char_lcd_i2c_expander_sequencer_top_assert.svh"

  `LCDSEQ_ASSERT(a_phase_range, busy_q |-> (phase_q != 2'd3), "step phase out of range")
  `LCDSEQ_ASSERT(a_bytes_contiguous, mid_item |=> strobe_q, "gap inside an item")
  `LCDSEQ_ASSERT(a_flags_stable, mid_item |=> $stable(item_flags), "flags changed inside an item")
  `LCDSEQ_ASSERT_ALWAYS(a_no_strobe_in_reset, !rst_ni |-> !strobe_o, "strobe during reset")

endmodule

`default_nettype wire

[test/char_lcd_i2c_expander_sequencer_top_tb.sv]
`timescale 1ns / 100ps

module char_lcd_i2c_expander_sequencer_top_tb;

  // Expander byte bits and selects, init program constants, and an unused register index.
  localparam logic [7:0] BitBacklight = 8'h08;
  localparam logic [7:0] BitEnable    = 8'h04;
  localparam logic       SelCmd       = 1'b0;
  localparam logic       SelData      = 1'b1;
  localparam logic [7:0] NibWake      = 8'h30;
  localparam logic [7:0] NibFourBit   = 8'h20;
  localparam logic [7:0] CmdFuncSet   = 8'h28;
  localparam logic [7:0] CmdEntryMode = 8'h06;
  localparam logic [7:0] CmdDispOn    = 8'h0C;
  localparam logic [1:0] RegUnused    = 2'd3;

  // One expander write as it leaves the block.
  typedef struct {
    logic [7:0]  addr;
    logic [7:0]  xbyte;
    logic [13:0] wait_us;
    logic        rclamp;
    logic        csat;
    logic        lst;
  } lcd_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        start_i = 1'b0;
  logic [2:0]  opcode_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [2:0]  row_i = '0;
  logic [5:0]  column_i = '0;
  logic [7:0]  text_length_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i = '0;
  logic        busy_o;
  logic        strobe_o;
  logic [7:0]  address_byte_o;
  logic [7:0]  expander_byte_o;
  logic [13:0] wait_after_us_o;
  logic        row_clamped_o;
  logic        column_saturated_o;
  logic        last_o;

  // Shadow copy of the configuration registers.
  logic [6:0] cfg_dev_addr = lcdseq_pkg::DevAddrReset;
  logic [2:0] cfg_rows = lcdseq_pkg::MaxRowsReset;
  logic [5:0] cfg_cols = lcdseq_pkg::MaxColsReset;

  lcd_write_t lcd_writes_q[$];
  lcd_write_t burst_q[$];
  logic       row_flag;
  logic       col_flag;
  bit         gaps_on = 1'b1;
  int         error_count = 0;

  char_lcd_i2c_expander_sequencer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .opcode_i          (opcode_i),
    .data_byte_i       (data_byte_i),
    .row_i             (row_i),
    .column_i          (column_i),
    .text_length_i     (text_length_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .strobe_o          (strobe_o),
    .address_byte_o    (address_byte_o),
    .expander_byte_o   (expander_byte_o),
    .wait_after_us_o   (wait_after_us_o),
    .row_clamped_o     (row_clamped_o),
    .column_saturated_o(column_saturated_o),
    .last_o            (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Appends one expander byte to the burst being built.
  function automatic void add_byte(input logic [7:0] b, input logic [13:0] w);
    lcd_write_t e;
    e.addr    = {cfg_dev_addr, 1'b0};
    e.xbyte   = b;
    e.wait_us = w;
    e.rclamp  = 1'b0;
    e.csat    = 1'b0;
    e.lst     = 1'b0;
    burst_q.push_back(e);
  endfunction

  // A nibble is strobed in with three bytes: setup, enable high, enable low.
  function automatic void add_nibble(input logic [7:0] hi, input logic sel,
                                     input logic [13:0] extra);
    logic [7:0] d;
    d = (hi & 8'hF0) | {7'b0, sel} | BitBacklight;
    add_byte(d, lcdseq_pkg::WaitSetup);
    add_byte(d | BitEnable, lcdseq_pkg::WaitPulse);
    add_byte(d & ~BitEnable, lcdseq_pkg::WaitSettle + extra);
  endfunction

  // A full byte goes out high nibble first.
  function automatic void add_full(input logic [7:0] v, input logic sel,
                                   input logic [13:0] extra);
    add_nibble({v[7:4], 4'h0}, sel, 14'd0);
    add_nibble({v[3:0], 4'h0}, sel, extra);
  endfunction

  // Cursor move: the row is limited to the usable rows, the address wraps at 128.
  function automatic void add_cursor(input logic [2:0] r, input logic [5:0] c);
    logic [2:0] last_row;
    logic [6:0] offs;
    logic [6:0] ddr;
    if (cfg_rows == 3'd0) last_row = 3'd0;
    else if (cfg_rows > 3'd4) last_row = 3'd3;
    else last_row = cfg_rows - 3'd1;
    if (r > last_row) begin
      r = last_row;
      row_flag = 1'b1;
    end
    case (r[1:0])
      2'd0: offs = lcdseq_pkg::RowOffset0;
      2'd1: offs = lcdseq_pkg::RowOffset1;
      2'd2: offs = lcdseq_pkg::RowOffset2;
      default: offs = lcdseq_pkg::RowOffset3;
    endcase
    ddr = {1'b0, c} + offs;
    add_full(lcdseq_pkg::CmdSetDdr | {1'b0, ddr}, SelCmd, 14'd0);
  endfunction

  // Works out every expander write that one accepted item causes.
  function automatic void expand_item(input logic [2:0] op, input logic [7:0] dat,
                                      input logic [2:0] r, input logic [5:0] c,
                                      input logic [7:0] len);
    logic [5:0] col;
    burst_q.delete();
    row_flag = 1'b0;
    col_flag = 1'b0;
    case (op)
      lcdseq_pkg::OpInit: begin
        add_nibble(NibWake, SelCmd, 14'd10000);
        add_nibble(NibWake, SelCmd, 14'd200);
        add_nibble(NibWake, SelCmd, 14'd0);
        add_nibble(NibFourBit, SelCmd, 14'd80);
        add_full(CmdFuncSet, SelCmd, 14'd80);
        add_full(lcdseq_pkg::CmdClear, SelCmd, 14'd2000);
        add_full(CmdEntryMode, SelCmd, 14'd80);
        add_full(CmdDispOn, SelCmd, 14'd0);
      end
      lcdseq_pkg::OpCommand: add_full(dat, SelCmd, 14'd0);
      lcdseq_pkg::OpChar: add_full(dat, SelData, 14'd0);
      lcdseq_pkg::OpClear: add_full(lcdseq_pkg::CmdClear, SelCmd, 14'd2000);
      lcdseq_pkg::OpHome: add_full(lcdseq_pkg::CmdHome, SelCmd, 14'd2000);
      lcdseq_pkg::OpCursor: add_cursor(r, c);
      lcdseq_pkg::OpNextLine: add_cursor(3'd1, 6'd0);
      default: begin
        if (len > {2'b0, cfg_cols}) begin
          col = 6'd0;
          col_flag = 1'b1;
        end else begin
          col = cfg_cols - len[5:0];
        end
        add_cursor(r, col);
      end
    endcase
    foreach (burst_q[k]) begin
      burst_q[k].rclamp = row_flag;
      burst_q[k].csat   = col_flag;
      burst_q[k].lst    = (k == burst_q.size() - 1);
      lcd_writes_q.push_back(burst_q[k]);
    end
  endfunction

  // Each strobed result is compared against the oldest expected write.
  always @(posedge clk_i) begin
    lcd_write_t e;
    if (rst_ni && strobe_o) begin
      if (lcd_writes_q.size() == 0) begin
        $display("%0t: unexpected result, expander byte %h", $time, expander_byte_o);
        error_count++;
      end else begin
        e = lcd_writes_q.pop_front();
        if (address_byte_o !== e.addr) begin
          $display("%0t: address_byte expected %h actual %h", $time, e.addr, address_byte_o);
          error_count++;
        end
        if (expander_byte_o !== e.xbyte) begin
          $display("%0t: expander_byte expected %h actual %h", $time, e.xbyte,
                   expander_byte_o);
          error_count++;
        end
        if (wait_after_us_o !== e.wait_us) begin
          $display("%0t: wait_after_us expected %0d actual %0d", $time, e.wait_us,
                   wait_after_us_o);
          error_count++;
        end
        if (row_clamped_o !== e.rclamp) begin
          $display("%0t: row_clamped expected %b actual %b", $time, e.rclamp, row_clamped_o);
          error_count++;
        end
        if (column_saturated_o !== e.csat) begin
          $display("%0t: column_saturated expected %b actual %b", $time, e.csat,
                   column_saturated_o);
          error_count++;
        end
        if (last_o !== e.lst) begin
          $display("%0t: last expected %b actual %b", $time, e.lst, last_o);
          error_count++;
        end
      end
    end
  end

  // Sends one item and records what it should produce once the block takes it.
  task automatic issue_item(input logic [2:0] op, input logic [7:0] dat,
                            input logic [2:0] r, input logic [5:0] c,
                            input logic [7:0] len);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    opcode_i      <= op;
    data_byte_i   <= dat;
    row_i         <= r;
    column_i      <= c;
    text_length_i <= len;
    do @(posedge clk_i); while (busy_o);
    expand_item(op, dat, r, c, len);
  endtask

  // Holds off new items until every expected write has come out.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (lcd_writes_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Writes one configuration register while the block is idle.
  task automatic set_reg(input logic [1:0] idx, input logic [6:0] val);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_index_i <= 2'($urandom);
    cfg_data_i  <= 7'($urandom);
    case (idx)
      lcdseq_pkg::RegDevAddr: cfg_dev_addr = val;
      lcdseq_pkg::RegMaxRows: cfg_rows = val[2:0];
      lcdseq_pkg::RegMaxCols: cfg_cols = val[5:0];
      default: ;
    endcase
  endtask

  // Every opcode and the field extremes under the reset configuration.
  task automatic test_reset_defaults();
    issue_item(lcdseq_pkg::OpInit, 8'h00, 3'd0, 6'd0, 8'd0);
    issue_item(lcdseq_pkg::OpCommand, 8'h00, 3'd0, 6'd0, 8'd0);
    issue_item(lcdseq_pkg::OpCommand, 8'hFF, 3'd7, 6'd63, 8'd255);
    issue_item(lcdseq_pkg::OpChar, 8'h00, 3'd0, 6'd0, 8'd0);
    issue_item(lcdseq_pkg::OpChar, 8'hFF, 3'd0, 6'd0, 8'd0);
    issue_item(lcdseq_pkg::OpChar, 8'h5A, 3'd0, 6'd0, 8'd0);
    issue_item(lcdseq_pkg::OpClear, 8'h00, 3'd0, 6'd0, 8'd0);
    issue_item(lcdseq_pkg::OpHome, 8'h00, 3'd0, 6'd0, 8'd0);
    issue_item(lcdseq_pkg::OpCursor, 8'h00, 3'd0, 6'd0, 8'd0);
    issue_item(lcdseq_pkg::OpCursor, 8'h00, 3'd1, 6'd63, 8'd0);
    issue_item(lcdseq_pkg::OpCursor, 8'h00, 3'd7, 6'd5, 8'd0);
    issue_item(lcdseq_pkg::OpNextLine, 8'h00, 3'd0, 6'd0, 8'd0);
    issue_item(lcdseq_pkg::OpRightAln, 8'h00, 3'd0, 6'd0, 8'd0);
    issue_item(lcdseq_pkg::OpRightAln, 8'h00, 3'd1, 6'd0, 8'd16);
    issue_item(lcdseq_pkg::OpRightAln, 8'h00, 3'd0, 6'd0, 8'd17);
    issue_item(lcdseq_pkg::OpRightAln, 8'h00, 3'd7, 6'd0, 8'd255);
  endtask

  // A write to the index past the register list must change nothing.
  task automatic test_unused_index();
    set_reg(RegUnused, 7'h7F);
    issue_item(lcdseq_pkg::OpCursor, 8'h00, 3'd3, 6'd0, 8'd0);
  endtask

  // With one row, or a row count of zero, next line and row 1 are clamped.
  task automatic test_single_row();
    set_reg(lcdseq_pkg::RegMaxRows, 7'h79);
    issue_item(lcdseq_pkg::OpNextLine, 8'h00, 3'd0, 6'd0, 8'd0);
    set_reg(lcdseq_pkg::RegMaxRows, 7'h00);
    issue_item(lcdseq_pkg::OpCursor, 8'h00, 3'd1, 6'd2, 8'd0);
  endtask

  // Row counts above four act as four; the DDRAM address wraps past 127.
  task automatic test_four_rows();
    set_reg(lcdseq_pkg::RegMaxRows, 7'h07);
    issue_item(lcdseq_pkg::OpCursor, 8'h00, 3'd3, 6'd63, 8'd0);
    issue_item(lcdseq_pkg::OpCursor, 8'h00, 3'd4, 6'd0, 8'd0);
    set_reg(lcdseq_pkg::RegMaxRows, 7'h04);
    issue_item(lcdseq_pkg::OpCursor, 8'h00, 3'd2, 6'd10, 8'd0);
  endtask

  // Extreme device addresses and column counts.
  task automatic test_address_and_columns();
    set_reg(lcdseq_pkg::RegDevAddr, 7'h00);
    set_reg(lcdseq_pkg::RegMaxCols, 7'h40);
    issue_item(lcdseq_pkg::OpRightAln, 8'h00, 3'd0, 6'd0, 8'd0);
    issue_item(lcdseq_pkg::OpRightAln, 8'h00, 3'd1, 6'd0, 8'd1);
    set_reg(lcdseq_pkg::RegDevAddr, 7'h7F);
    set_reg(lcdseq_pkg::RegMaxCols, 7'h3F);
    issue_item(lcdseq_pkg::OpRightAln, 8'h00, 3'd2, 6'd0, 8'd63);
    issue_item(lcdseq_pkg::OpChar, 8'hA5, 3'd0, 6'd0, 8'd0);
  endtask

  // Random items over several random configurations.
  task automatic test_random_phases();
    logic [2:0] op;
    logic [7:0] len;
    logic [6:0] val;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 2))
        0: val = 7'h00;
        1: val = 7'h7F;
        default: val = 7'($urandom);
      endcase
      set_reg(lcdseq_pkg::RegDevAddr, val);
      set_reg(lcdseq_pkg::RegMaxRows, {4'($urandom), 3'($urandom_range(0, 7))});
      case ($urandom_range(0, 4))
        0: val = 7'd0;
        1: val = 7'd1;
        2: val = 7'd40;
        3: val = 7'd63;
        default: val = 7'($urandom);
      endcase
      set_reg(lcdseq_pkg::RegMaxCols, val);
      for (int n = 0; n < 24; n++) begin
        // Each stretch of items is randomly back-to-back or gapped.
        if (n % 9 == 0) gaps_on = $urandom_range(0, 1);
        if (n == 13 && phase % 2 == 0) wait_drained();
        op = ($urandom_range(0, 15) == 0) ? lcdseq_pkg::OpInit : 3'($urandom_range(1, 7));
        if ($urandom_range(0, 1) == 1) len = 8'($urandom_range(0, cfg_cols + 2));
        else len = 8'($urandom);
        issue_item(op, 8'($urandom), 3'($urandom), 6'($urandom), len);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_unused_index();
    test_single_row();
    test_four_rows();
    test_address_and_columns();
    test_random_phases();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("char_lcd_i2c_expander_sequencer_top_tb: done, clean");
    end else begin
      $display("char_lcd_i2c_expander_sequencer_top_tb: done, errors");
    end
    $finish;
  end

  // Guards against a hang.
  initial begin
    #3000000;
    $display("char_lcd_i2c_expander_sequencer_top_tb: done, errors");
    $finish;
  end

endmodule
